// ===== hw/rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, operation codes and controller/datapath interface structs
// for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

   localparam int DATA_W = 64;
   localparam int CNT_W  = 6;   // counts the DATA_W bit steps of one modular operation

   // Datapath operation selected by the controller
   localparam logic [1:0] OP_RED = 2'd0;  // base mod modulus
   localparam logic [1:0] OP_MUL = 2'd1;  // acc = base * acc mod modulus
   localparam logic [1:0] OP_SQR = 2'd2;  // base = base * base mod modulus

   typedef struct packed {
      logic       load;      // capture a new request
      logic       start;     // clear remainder, load multiplier bits
      logic       step;      // one shift-add-reduce step
      logic       commit;    // write the finished remainder back
      logic       out_load;  // fill the response register
      logic [1:0] op;
   } mexp_cmd_type;

   typedef struct packed {
      logic bad;      // modulus of the current request is zero
      logic e_zero;   // no exponent bits left
      logic e_lsb;    // current exponent bit
   } mexp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mexp_dp.sv =====
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers, shared shift-add modular reducer and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_dp
   import mexp_pkg::*;
(
   input  wire logic                clock,
   input  wire mexp_cmd_type        cmd,
   output      mexp_status_type     status,
   input  wire logic [DATA_W-1:0]   req_base_value,
   input  wire logic [DATA_W-1:0]   req_exponent,
   input  wire logic [DATA_W-1:0]   req_modulus,
   output      logic [DATA_W-1:0]   rsp_power_result,
   output      logic                rsp_bad_modulus
);

   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] e_ff, e_in;
   logic [DATA_W-1:0] m_ff, m_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] mq_ff, mq_in;
   logic              bad_ff, bad_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              flag_ff, flag_in;

   logic [DATA_W:0]   dbl;
   logic [DATA_W:0]   dbl_red;
   logic [DATA_W-1:0] addend;
   logic [DATA_W:0]   sum;
   logic [DATA_W:0]   sum_red;
   logic [DATA_W:0]   m_ext;

   // One step: r = ((2r mod m) + bit * addend) mod m, addend <= m
   always_comb begin
      m_ext   = {1'b0, m_ff};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
      addend  = (cmd.op == OP_RED) ? DATA_W'(1) : b_ff;
      sum     = {1'b0, dbl_red[DATA_W-1:0]} + (mq_ff[DATA_W-1] ? {1'b0, addend} : '0);
      sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
   end

   always_comb begin
      b_in    = b_ff;
      acc_in  = acc_ff;
      e_in    = e_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      mq_in   = mq_ff;
      bad_in  = bad_ff;
      res_in  = res_ff;
      flag_in = flag_ff;

      if (cmd.load) begin
         b_in   = req_base_value;
         e_in   = req_exponent;
         m_in   = req_modulus;
         acc_in = DATA_W'(1);
         bad_in = (req_modulus == '0);
         r_in   = '0;
         mq_in  = req_base_value;
      end

      if (cmd.start) begin
         r_in  = '0;
         mq_in = (cmd.op == OP_MUL) ? acc_ff : b_ff;
      end

      if (cmd.step) begin
         r_in  = sum_red[DATA_W-1:0];
         mq_in = {mq_ff[DATA_W-2:0], 1'b0};
      end

      // commit the remainder that the last step produces
      if (cmd.commit) begin
         case (cmd.op)
            OP_MUL: begin
               acc_in = sum_red[DATA_W-1:0];
            end
            OP_SQR: begin
               b_in = sum_red[DATA_W-1:0];
               e_in = {1'b0, e_ff[DATA_W-1:1]};
            end
            default: begin
               b_in = sum_red[DATA_W-1:0];
            end
         endcase
      end

      if (cmd.out_load) begin
         res_in  = bad_ff ? '0 : acc_ff;
         flag_in = bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      r_ff    <= r_in;
      mq_ff   <= mq_in;
      bad_ff  <= bad_in;
      res_ff  <= res_in;
      flag_ff <= flag_in;
   end

   assign status.bad    = bad_ff;
   assign status.e_zero = (e_ff == '0);
   assign status.e_lsb  = e_ff[0];

   assign rsp_power_result = res_ff;
   assign rsp_bad_modulus  = flag_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences the reduce / multiply / square operations over the
// exponent bits and runs both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl
   import mexp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      mexp_cmd_type    cmd,
   input  wire mexp_status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_PICK   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SQR    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             mul_done_ff, mul_done_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             cnt_last;

   assign cnt_last = &cnt_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mul_done_in  = mul_done_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.op       = OP_RED;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               cnt_in      = '0;
               mul_done_in = 1'b0;
               state_in    = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.op   = OP_RED;
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               cmd.commit = 1'b1;
               state_in   = ST_PICK;
            end
         end
         ST_PICK: begin
            cnt_in = '0;
            if (status.bad || status.e_zero) begin
               state_in = ST_FINISH;
            end else if (status.e_lsb && !mul_done_ff) begin
               cmd.op      = OP_MUL;
               cmd.start   = 1'b1;
               mul_done_in = 1'b1;
               state_in    = ST_MUL;
            end else begin
               cmd.op      = OP_SQR;
               cmd.start   = 1'b1;
               mul_done_in = 1'b0;
               state_in    = ST_SQR;
            end
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               cmd.commit = 1'b1;
               state_in   = ST_PICK;
            end
         end
         ST_SQR: begin
            cmd.op   = OP_SQR;
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               cmd.commit = 1'b1;
               state_in   = ST_PICK;
            end
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mul_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mul_done_ff  <= mul_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/modular_exponentiation.sv =====
// Sequence from request accept to rsp_valid: the base reduction, then a pick state and one full
//   reducer pass per modular multiply or square, then a last pick and the finish state.
// Throughput: one request at a time; req_ready returns once the controller is back in idle
//   after the response loads. An all-ones exponent takes 128 modular multiplies and squares.
// A zero modulus still runs the base reduction, then answers without any multiply or square.
// Reset (synchronous, active high) returns the controller to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply: base^exponent mod modulus over 64-bit
// operands, with exact 128-bit-equivalent products via a shift-add reducer.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation
   import mexp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [DATA_W-1:0] req_base_value,
   input  wire logic [DATA_W-1:0] req_exponent,
   input  wire logic [DATA_W-1:0] req_modulus,
   // response channel
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [DATA_W-1:0] rsp_power_result,
   output      logic              rsp_bad_modulus
);

   // Command and status between the sequencer and the arithmetic.
   mexp_cmd_type    cmd;
   mexp_status_type status;

   // Controller: walks the exponent bits, one reducer operation at a time.
   // The response register lets a new request enter while the last
   // response still waits on rsp_ready.
   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: base, accumulator, exponent, modulus and the reducer that
   // forms (a * b) mod m one multiplier bit per cycle, MSB first.
   mexp_dp u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_base_value   (req_base_value),
      .req_exponent     (req_exponent),
      .req_modulus      (req_modulus),
      .rsp_power_result (rsp_power_result),
      .rsp_bad_modulus  (rsp_bad_modulus)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker
   import mexp_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DATA_W-1:0] rsp_power_result,
   input wire logic              rsp_bad_modulus
);

   // An error response always carries a zero result
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_modulus |-> rsp_power_result == '0)
      else $error("bad modulus response with nonzero result");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power_result)
         && $stable(rsp_bad_modulus))
      else $error("response dropped or changed while stalled");

   // The block is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in flight");

   // No response shows up the cycle after a reset cycle
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

`default_nettype wire
